/* sv/brfs_pkg.sv */
// ----------------------------------------------------------------------------
// brfs_pkg
// Shared types, command codes and mode helpers for the banked register file.
// ----------------------------------------------------------------------------
`default_nettype none

package brfs_pkg;

    typedef enum logic [3:0] {
        CMD_RDREG     = 4'd0,
        CMD_WRREG     = 4'd1,
        CMD_RDUSER    = 4'd2,
        CMD_WRUSER    = 4'd3,
        CMD_RDCPSR    = 4'd4,
        CMD_WRCPSR    = 4'd5,
        CMD_RDSPSR    = 4'd6,
        CMD_WRSPSR    = 4'd7,
        CMD_CPSR2SPSR = 4'd8,
        CMD_SPSR2CPSR = 4'd9
    } cmd_t;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [3:0]  reg_num;
        logic [31:0] write_value;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] status_now;
        logic        mode_error;
    } rsp_t;

    localparam int unsigned NUM_LIVE  = 16;
    localparam int unsigned NUM_BANKS = 6;
    localparam int unsigned NUM_SLOTS = 7;

    localparam logic [31:0] SPSR_MASK = 32'hf000_00ff;
    localparam logic [31:0] PC_MASK_T = 32'hffff_fffe;
    localparam logic [31:0] PC_MASK_A = 32'hffff_fffc;

    localparam logic [4:0] MODE_USR   = 5'h10;
    localparam logic [4:0] MODE_FAST  = 5'h11;
    localparam logic [4:0] MODE_INTR  = 5'h12;
    localparam logic [4:0] MODE_SUPER = 5'h13;
    localparam logic [4:0] MODE_ABORT = 5'h17;
    localparam logic [4:0] MODE_UNDEF = 5'h1b;
    localparam logic [4:0] MODE_SYS   = 5'h1f;

    localparam logic [2:0] BANK_USR = 3'd0;
    localparam logic [2:0] BANK_FIQ = 3'd1;
    localparam logic [2:0] BANK_IRQ = 3'd2;
    localparam logic [2:0] BANK_SVC = 3'd3;
    localparam logic [2:0] BANK_ABT = 3'd4;
    localparam logic [2:0] BANK_UND = 3'd5;

    localparam logic [31:0] RST_R0     = 32'h0000_0ca5;
    localparam logic [31:0] RST_SP     = 32'h0300_7f00;
    localparam logic [31:0] RST_PC     = 32'h0800_0000;
    localparam logic [31:0] RST_EXC_SP = 32'h0300_7fe0;

    function automatic logic mode_ok(input logic [4:0] m);
        logic ok;
        case (m)
            MODE_USR, MODE_FAST, MODE_INTR, MODE_SUPER,
            MODE_ABORT, MODE_UNDEF, MODE_SYS: ok = 1'b1;
            default:                          ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [2:0] bank_of(input logic [4:0] m);
        logic [2:0] b;
        case (m)
            MODE_FAST:  b = BANK_FIQ;
            MODE_INTR:  b = BANK_IRQ;
            MODE_SUPER: b = BANK_SVC;
            MODE_ABORT: b = BANK_ABT;
            MODE_UNDEF: b = BANK_UND;
            default:    b = BANK_USR;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* sv/brfs_core.sv */
// ----------------------------------------------------------------------------
// brfs_core
// Architectural state: live registers, mode banks, saved and current status.
// Applies one command per fire and presents the result beat combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module brfs_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire brfs_pkg::req_t req,
    output brfs_pkg::rsp_t      rsp
);

    logic [31:0] live_reg  [brfs_pkg::NUM_LIVE];
    logic [31:0] live_next [brfs_pkg::NUM_LIVE];
    logic [31:0] bank_reg  [brfs_pkg::NUM_BANKS][brfs_pkg::NUM_SLOTS];
    logic [31:0] bank_next [brfs_pkg::NUM_BANKS][brfs_pkg::NUM_SLOTS];
    logic [31:0] saved_reg  [brfs_pkg::NUM_BANKS];
    logic [31:0] saved_next [brfs_pkg::NUM_BANKS];
    logic [4:0]  mode_reg,  mode_next;
    logic        thumb_reg, thumb_next;
    logic        fiq_reg,   fiq_next;
    logic        irq_reg,   irq_next;
    logic [3:0]  flags_reg, flags_next;

    logic [2:0]  cur_bank;
    logic [2:0]  new_bank;
    logic [31:0] status_cur;
    logic [31:0] ws_val;
    logic        do_ws;
    logic        user_hit;
    logic [2:0]  user_slot;
    logic [31:0] pc_val;
    logic [31:0] rd;
    logic        err;

    assign cur_bank   = brfs_pkg::bank_of(mode_reg);
    assign status_cur = {flags_reg, 20'd0, irq_reg, fiq_reg, thumb_reg, mode_reg};
    assign user_slot  = req.reg_num[2:0];
    assign user_hit   = ((cur_bank == brfs_pkg::BANK_FIQ) && (req.reg_num >= 4'd8)
                          && (req.reg_num <= 4'd14))
                     || ((cur_bank != brfs_pkg::BANK_USR)
                          && ((req.reg_num == 4'd13) || (req.reg_num == 4'd14)));
    assign pc_val     = (req.reg_num == 4'd15)
                      ? (req.write_value & (thumb_reg ? brfs_pkg::PC_MASK_T
                                                      : brfs_pkg::PC_MASK_A))
                      : req.write_value;

    always_comb
    begin
        live_next  = live_reg;
        bank_next  = bank_reg;
        saved_next = saved_reg;
        mode_next  = mode_reg;
        thumb_next = thumb_reg;
        fiq_next   = fiq_reg;
        irq_next   = irq_reg;
        flags_next = flags_reg;
        rd         = 32'd0;
        err        = 1'b0;
        do_ws      = 1'b0;
        ws_val     = req.write_value;
        new_bank   = brfs_pkg::bank_of(ws_val[4:0]);

        case (brfs_pkg::cmd_t'(req.cmd))
            brfs_pkg::CMD_RDREG:
            begin
                rd = live_reg[req.reg_num];
            end
            brfs_pkg::CMD_WRREG:
            begin
                live_next[req.reg_num] = pc_val;
                rd = req.write_value;
            end
            brfs_pkg::CMD_RDUSER:
            begin
                rd = user_hit ? bank_reg[brfs_pkg::BANK_USR][user_slot]
                              : live_reg[req.reg_num];
            end
            brfs_pkg::CMD_WRUSER:
            begin
                if (user_hit)
                begin
                    bank_next[brfs_pkg::BANK_USR][user_slot] = req.write_value;
                end
                else
                begin
                    live_next[req.reg_num] = pc_val;
                end
                rd = req.write_value;
            end
            brfs_pkg::CMD_RDCPSR:
            begin
                rd = status_cur;
            end
            brfs_pkg::CMD_WRCPSR:
            begin
                do_ws = 1'b1;
                rd    = req.write_value;
            end
            brfs_pkg::CMD_RDSPSR:
            begin
                rd = (cur_bank == brfs_pkg::BANK_USR) ? status_cur : saved_reg[cur_bank];
            end
            brfs_pkg::CMD_WRSPSR:
            begin
                if (cur_bank != brfs_pkg::BANK_USR)
                begin
                    saved_next[cur_bank] = req.write_value & brfs_pkg::SPSR_MASK;
                end
                rd = req.write_value;
            end
            brfs_pkg::CMD_CPSR2SPSR:
            begin
                if (cur_bank != brfs_pkg::BANK_USR)
                begin
                    saved_next[cur_bank] = status_cur & brfs_pkg::SPSR_MASK;
                end
            end
            brfs_pkg::CMD_SPSR2CPSR:
            begin
                do_ws  = (cur_bank != brfs_pkg::BANK_USR);
                ws_val = saved_reg[cur_bank];
            end
            default:
            begin
                rd = 32'd0;
            end
        endcase

        new_bank = brfs_pkg::bank_of(ws_val[4:0]);

        if (do_ws)
        begin
            if (!brfs_pkg::mode_ok(ws_val[4:0]))
            begin
                err = 1'b1;
            end
            else
            begin
                mode_next = ws_val[4:0];
                if (new_bank != cur_bank)
                begin
                    if ((cur_bank == brfs_pkg::BANK_FIQ) || (new_bank == brfs_pkg::BANK_FIQ))
                    begin
                        for (int i = 0; i < 5; i++)
                        begin
                            bank_next[cur_bank][3'(i)] = live_reg[4'(8 + i)];
                            live_next[4'(8 + i)]       = bank_reg[new_bank][3'(i)];
                        end
                    end
                    bank_next[cur_bank][3'd5] = live_reg[13];
                    bank_next[cur_bank][3'd6] = live_reg[14];
                    live_next[13]             = bank_reg[new_bank][3'd5];
                    live_next[14]             = bank_reg[new_bank][3'd6];
                end
            end
            thumb_next = ws_val[5];
            fiq_next   = ws_val[6];
            irq_next   = ws_val[7];
            flags_next = ws_val[31:28];
        end
    end

    assign rsp.read_data  = rd;
    assign rsp.status_now = {flags_next, 20'd0, irq_next, fiq_next, thumb_next, mode_next};
    assign rsp.mode_error = err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < brfs_pkg::NUM_LIVE; i++)
            begin
                live_reg[i] <= 32'd0;
            end
            live_reg[0]  <= brfs_pkg::RST_R0;
            live_reg[13] <= brfs_pkg::RST_SP;
            live_reg[15] <= brfs_pkg::RST_PC;
            for (int b = 0; b < brfs_pkg::NUM_BANKS; b++)
            begin
                for (int s = 0; s < brfs_pkg::NUM_SLOTS; s++)
                begin
                    bank_reg[b][s] <= 32'd0;
                end
                saved_reg[b] <= 32'd0;
            end
            bank_reg[brfs_pkg::BANK_IRQ][3'd5] <= brfs_pkg::RST_EXC_SP;
            bank_reg[brfs_pkg::BANK_SVC][3'd5] <= brfs_pkg::RST_EXC_SP;
            mode_reg  <= brfs_pkg::MODE_SYS;
            thumb_reg <= 1'b0;
            fiq_reg   <= 1'b0;
            irq_reg   <= 1'b0;
            flags_reg <= 4'd0;
        end
        else if (fire)
        begin
            live_reg  <= live_next;
            bank_reg  <= bank_next;
            saved_reg <= saved_next;
            mode_reg  <= mode_next;
            thumb_reg <= thumb_next;
            fiq_reg   <= fiq_next;
            irq_reg   <= irq_next;
            flags_reg <= flags_next;
        end
    end

    a_mode_valid: assert property (@(posedge clk) disable iff (!rst_n)
        brfs_pkg::mode_ok(mode_reg))
        else $error("mode register holds an invalid mode");

    a_err_keeps_mode: assert property (@(posedge clk) disable iff (!rst_n)
        fire && err |=> $stable(mode_reg))
        else $error("mode changed on a rejected status write");

    a_pc_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (req.cmd == brfs_pkg::CMD_WRREG) && (req.reg_num == 4'd15)
        |=> (live_reg[15][0] == 1'b0))
        else $error("program counter write left bit 0 set");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(mode_reg) && $stable(flags_reg) && $stable(thumb_reg))
        else $error("status changed without a command");

endmodule

`default_nettype wire

/* sv/banked_register_file_with_status.sv */
// ----------------------------------------------------------------------------
// banked_register_file_with_status
// Mode-banked register file with current and saved status words.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one command beat: cmd,
//   reg_num and write_value. rsp channel (rsp_valid/rsp_ready/rsp) returns
//   exactly one beat per command: read_data, status_now and mode_error.
//   A beat is held in the input register, then the command is applied
//   to the state and its result is captured in the output register, so the
//   result beat is valid after passing both registers, and one command is
//   accepted every cycle while rsp_ready keeps the output draining. A mode
//   change swaps the banked registers in parallel as its command is applied.
//   When rsp_ready is low the output register holds its beat, the input
//   register still takes one more beat, and req_ready then drops until the
//   output drains. Reset (rst_n low, asynchronous) empties both stages and
//   loads the boot values: system mode, r0, r13 and the program counter
//   preset, and the IRQ and SVC stack pointers preset in their banks.
// ----------------------------------------------------------------------------
`default_nettype none

module banked_register_file_with_status (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output      logic           req_ready,
    input  wire brfs_pkg::req_t req,
    output      logic           rsp_valid,
    input  wire logic           rsp_ready,
    output brfs_pkg::rsp_t      rsp
);

    logic           stage_valid_reg;
    brfs_pkg::req_t stage_reg;
    logic           out_valid_reg;
    brfs_pkg::rsp_t out_reg;
    brfs_pkg::rsp_t core_rsp;
    logic           fire;

    assign fire      = stage_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !stage_valid_reg || fire;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    brfs_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (stage_reg),
        .rsp   (core_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                stage_valid_reg <= req_valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            stage_reg <= req;
        end
        if (fire)
        begin
            out_reg <= core_rsp;
        end
    end

endmodule

`default_nettype wire

/* dv/banked_register_file_with_status_test.sv */
// ----------------------------------------------------------------------------
// banked_register_file_with_status_test
// Self-checking bench for the mode-banked register file. A directed run
// covers boot values, PC alignment, invalid modes, the user-bank view and
// the saved-status commands. A long random run follows, biased toward legal
// mode switches. Responses are checked against an in-bench model of the
// register banks and status words. Both handshakes idle at random, and one
// long response hold-off backs the pipe up into the request side.
// ----------------------------------------------------------------------------
module banked_register_file_with_status_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         RANDOM_BEATS    = 1150;
    localparam int         CYCLE_LIMIT     = 500000;
    localparam int         HOLD_OFF_CYCLES = 80;
    localparam logic [3:0] CMD_SPARE_LO    = 4'd10;
    localparam logic [3:0] CMD_SPARE_HI    = 4'd15;
    localparam logic [4:0] MODE_BAD        = 5'h00;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    brfs_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    brfs_pkg::rsp_t rsp;

    // model state
    logic [31:0] gpr       [16];
    logic [31:0] shadow    [6][7];
    logic [31:0] spsr_bank [6];
    logic [4:0]  cur_mode;
    logic        t_bit;
    logic        f_bit;
    logic        i_bit;
    logic [3:0]  nzcv;

    brfs_pkg::req_t cmd_fifo     [$];
    brfs_pkg::rsp_t expected_rsp [$];
    brfs_pkg::rsp_t want_rsp;

    logic hold_off  = 1'b0;
    logic req_taken = 1'b0;
    int   req_wait  = 0;
    int   rsp_wait  = 0;
    int   req_calm  = 0;
    int   rsp_calm  = 0;
    int   beats_in  = 0;
    int   beats_out = 0;
    int   errors    = 0;
    int   cycles    = 0;
    int   mode_switches = 0;
    int   bad_modes     = 0;

    banked_register_file_with_status DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int bank_index(logic [4:0] m);
        case (m)
            brfs_pkg::MODE_USR, brfs_pkg::MODE_SYS: return 0;
            brfs_pkg::MODE_FAST:                    return 1;
            brfs_pkg::MODE_INTR:                    return 2;
            brfs_pkg::MODE_SUPER:                   return 3;
            brfs_pkg::MODE_ABORT:                   return 4;
            brfs_pkg::MODE_UNDEF:                   return 5;
            default:                                return -1;
        endcase
    endfunction

    function automatic logic [31:0] psr_word();
        return {nzcv, 20'd0, i_bit, f_bit, t_bit, cur_mode};
    endfunction

    function automatic void write_gpr(logic [3:0] n, logic [31:0] v);
        if (n == 4'd15)
            v &= t_bit ? brfs_pkg::PC_MASK_T : brfs_pkg::PC_MASK_A;
        gpr[n] = v;
    endfunction

    function automatic logic load_psr(logic [31:0] v);
        int   from_bank;
        int   to_bank;
        int   i;
        logic bad;
        from_bank = bank_index(cur_mode);
        to_bank   = bank_index(v[4:0]);
        bad       = (to_bank < 0);
        if (bad)
            bad_modes++;
        else
        begin
            cur_mode = v[4:0];
            if (from_bank != to_bank)
            begin
                mode_switches++;
                if (from_bank == 1 || to_bank == 1)
                    for (i = 0; i < 5; i++)
                    begin
                        shadow[from_bank][i] = gpr[8 + i];
                        gpr[8 + i] = shadow[to_bank][i];
                    end
                for (i = 5; i < 7; i++)
                begin
                    shadow[from_bank][i] = gpr[8 + i];
                    gpr[8 + i] = shadow[to_bank][i];
                end
            end
        end
        t_bit = v[5];
        f_bit = v[6];
        i_bit = v[7];
        nzcv  = v[31:28];
        return bad;
    endfunction

    // bank-0 slot seen through the user view, -1 for a live register
    function automatic int user_view_slot(logic [3:0] n);
        int b;
        b = bank_index(cur_mode);
        if (b == 0)
            return -1;
        if (b == 1 && n >= 4'd8 && n <= 4'd14)
            return int'(n) - 8;
        if (n >= 4'd13 && n <= 4'd14)
            return int'(n) - 8;
        return -1;
    endfunction

    function automatic brfs_pkg::rsp_t apply_command(brfs_pkg::req_t item);
        brfs_pkg::rsp_t r;
        int             b;
        int             s;
        r = '0;
        b = bank_index(cur_mode);
        if (b < 0)
            b = 0;
        case (item.cmd)
            brfs_pkg::CMD_RDREG:
                r.read_data = gpr[item.reg_num];
            brfs_pkg::CMD_WRREG:
            begin
                write_gpr(item.reg_num, item.write_value);
                r.read_data = item.write_value;
            end
            brfs_pkg::CMD_RDUSER:
            begin
                s = user_view_slot(item.reg_num);
                r.read_data = (s < 0) ? gpr[item.reg_num] : shadow[0][s];
            end
            brfs_pkg::CMD_WRUSER:
            begin
                s = user_view_slot(item.reg_num);
                if (s < 0)
                    write_gpr(item.reg_num, item.write_value);
                else
                    shadow[0][s] = item.write_value;
                r.read_data = item.write_value;
            end
            brfs_pkg::CMD_RDCPSR:
                r.read_data = psr_word();
            brfs_pkg::CMD_WRCPSR:
            begin
                r.mode_error = load_psr(item.write_value);
                r.read_data  = item.write_value;
            end
            brfs_pkg::CMD_RDSPSR:
                r.read_data = (b == 0) ? psr_word() : spsr_bank[b];
            brfs_pkg::CMD_WRSPSR:
            begin
                if (b != 0)
                    spsr_bank[b] = item.write_value & brfs_pkg::SPSR_MASK;
                r.read_data = item.write_value;
            end
            brfs_pkg::CMD_CPSR2SPSR:
                if (b != 0)
                    spsr_bank[b] = psr_word() & brfs_pkg::SPSR_MASK;
            brfs_pkg::CMD_SPSR2CPSR:
                if (b != 0)
                    r.mode_error = load_psr(spsr_bank[b]);
            default:
                ;
        endcase
        r.status_now = psr_word();
        return r;
    endfunction

    function automatic logic [4:0] pick_mode();
        case ($urandom_range(0, 6))
            0:       return brfs_pkg::MODE_USR;
            1:       return brfs_pkg::MODE_FAST;
            2:       return brfs_pkg::MODE_INTR;
            3:       return brfs_pkg::MODE_SUPER;
            4:       return brfs_pkg::MODE_ABORT;
            5:       return brfs_pkg::MODE_UNDEF;
            default: return brfs_pkg::MODE_SYS;
        endcase
    endfunction

    // mostly short gaps, a few long ones, and now and then a stretch of none
    function automatic int pick_gap(ref int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 199);
        if (r == 0)
        begin
            calm = $urandom_range(30, 80);
            return 0;
        end
        if (r < 110)
            return 0;
        if (r < 175)
            return $urandom_range(1, 3);
        if (r < 196)
            return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    task automatic queue_cmd(logic [3:0] c, logic [3:0] n, logic [31:0] v);
        brfs_pkg::req_t it;
        it.cmd         = c;
        it.reg_num     = n;
        it.write_value = v;
        cmd_fifo.push_back(it);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
        errors++;
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && !(req_valid && !req_taken))
        begin
            if (req_wait > 0)
            begin
                req_valid <= 1'b0;
                req_wait--;
            end
            else if (cmd_fifo.size() != 0)
            begin
                req       <= cmd_fifo.pop_front();
                req_valid <= 1'b1;
                req_wait = pick_gap(req_calm);
            end
            else
                req_valid <= 1'b0;
        end
    end

    // response ready
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off || rsp_wait > 0)
            begin
                rsp_ready <= 1'b0;
                if (rsp_wait > 0)
                    rsp_wait--;
            end
            else
            begin
                rsp_ready <= 1'b1;
                rsp_wait = pick_gap(rsp_calm);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        req_taken <= req_valid && req_ready;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                expected_rsp.push_back(apply_command(req));
                beats_in++;
            end
            if (rsp_valid && rsp_ready)
            begin
                beats_out++;
                if (expected_rsp.size() == 0)
                    report_mismatch("unexpected beat", rsp.read_data, '0);
                else
                begin
                    want_rsp = expected_rsp.pop_front();
                    if (rsp.read_data !== want_rsp.read_data)
                        report_mismatch("read_data", rsp.read_data, want_rsp.read_data);
                    if (rsp.status_now !== want_rsp.status_now)
                        report_mismatch("status_now", rsp.status_now, want_rsp.status_now);
                    if (rsp.mode_error !== want_rsp.mode_error)
                        report_mismatch("mode_error", {31'd0, rsp.mode_error},
                                        {31'd0, want_rsp.mode_error});
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycles, expected_rsp.size());
            $display("banked_register_file_with_status_test: errors");
            $finish;
        end
    end

    // long response hold-off to back up the pipe
    initial
    begin
        wait (beats_in >= 300);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        int             k;
        int             sel;
        int             total;
        brfs_pkg::req_t it;

        foreach (gpr[k])
            gpr[k] = '0;
        foreach (shadow[k, j])
            shadow[k][j] = '0;
        foreach (spsr_bank[k])
            spsr_bank[k] = '0;
        cur_mode = brfs_pkg::MODE_SYS;
        t_bit    = 1'b0;
        f_bit    = 1'b0;
        i_bit    = 1'b0;
        nzcv     = '0;
        gpr[0]   = brfs_pkg::RST_R0;
        gpr[13]  = brfs_pkg::RST_SP;
        gpr[15]  = brfs_pkg::RST_PC;
        shadow[brfs_pkg::BANK_IRQ][5] = brfs_pkg::RST_EXC_SP;
        shadow[brfs_pkg::BANK_SVC][5] = brfs_pkg::RST_EXC_SP;

        // directed
        queue_cmd(brfs_pkg::CMD_RDREG, 4'd0, '0);
        queue_cmd(brfs_pkg::CMD_RDREG, 4'd13, '0);
        queue_cmd(brfs_pkg::CMD_WRREG, 4'd15, 32'hffff_ffff);
        queue_cmd(brfs_pkg::CMD_RDREG, 4'd15, '0);
        queue_cmd(brfs_pkg::CMD_RDSPSR, 4'd0, '0);
        queue_cmd(brfs_pkg::CMD_WRSPSR, 4'd0, 32'hffff_ffff);
        queue_cmd(brfs_pkg::CMD_CPSR2SPSR, 4'd0, '0);
        queue_cmd(brfs_pkg::CMD_SPSR2CPSR, 4'd0, '0);
        queue_cmd(brfs_pkg::CMD_WRUSER, 4'd15, 32'hffff_ffff);
        queue_cmd(brfs_pkg::CMD_WRCPSR, 4'd0, {4'hf, 20'd0, 3'b111, MODE_BAD});
        queue_cmd(brfs_pkg::CMD_WRREG, 4'd15, 32'hffff_ffff);
        queue_cmd(brfs_pkg::CMD_RDCPSR, 4'd0, '0);
        queue_cmd(brfs_pkg::CMD_WRCPSR, 4'd0, {27'd0, brfs_pkg::MODE_FAST});
        queue_cmd(brfs_pkg::CMD_WRREG, 4'd8, 32'ha5a5_a5a5);
        queue_cmd(brfs_pkg::CMD_RDUSER, 4'd8, '0);
        queue_cmd(brfs_pkg::CMD_WRUSER, 4'd14, 32'h1234_5678);
        queue_cmd(brfs_pkg::CMD_CPSR2SPSR, 4'd0, '0);
        queue_cmd(brfs_pkg::CMD_WRSPSR, 4'd0, 32'hffff_ffff);
        queue_cmd(brfs_pkg::CMD_RDSPSR, 4'd0, '0);
        queue_cmd(brfs_pkg::CMD_SPSR2CPSR, 4'd0, '0);
        queue_cmd(brfs_pkg::CMD_WRCPSR, 4'd0, {27'd0, brfs_pkg::MODE_INTR});
        queue_cmd(brfs_pkg::CMD_RDREG, 4'd13, '0);
        queue_cmd(brfs_pkg::CMD_WRSPSR, 4'd0, '0);
        queue_cmd(brfs_pkg::CMD_SPSR2CPSR, 4'd0, '0);
        queue_cmd(brfs_pkg::CMD_RDUSER, 4'd13, '0);
        queue_cmd(brfs_pkg::CMD_WRCPSR, 4'd0, {27'd0, brfs_pkg::MODE_USR});
        queue_cmd(brfs_pkg::CMD_RDUSER, 4'd13, '0);
        queue_cmd(CMD_SPARE_LO, 4'd0, 32'hffff_ffff);
        queue_cmd(CMD_SPARE_HI, 4'd15, 32'hffff_ffff);

        // random, mostly legal mode switches
        for (k = 0; k < RANDOM_BEATS; k++)
        begin
            sel            = $urandom_range(0, 99);
            it.reg_num     = 4'($urandom_range(0, 15));
            it.write_value = $urandom;
            if ($urandom_range(0, 1) == 1)
                it.reg_num = 4'($urandom_range(8, 15));
            if (sel < 18)
                it.cmd = brfs_pkg::CMD_RDREG;
            else if (sel < 34)
                it.cmd = brfs_pkg::CMD_WRREG;
            else if (sel < 44)
                it.cmd = brfs_pkg::CMD_RDUSER;
            else if (sel < 52)
                it.cmd = brfs_pkg::CMD_WRUSER;
            else if (sel < 57)
                it.cmd = brfs_pkg::CMD_RDCPSR;
            else if (sel < 69)
            begin
                it.cmd = brfs_pkg::CMD_WRCPSR;
                if ($urandom_range(0, 9) < 8)
                    it.write_value[4:0] = pick_mode();
            end
            else if (sel < 75)
                it.cmd = brfs_pkg::CMD_RDSPSR;
            else if (sel < 82)
            begin
                it.cmd = brfs_pkg::CMD_WRSPSR;
                if ($urandom_range(0, 9) < 7)
                    it.write_value[4:0] = pick_mode();
            end
            else if (sel < 88)
                it.cmd = brfs_pkg::CMD_CPSR2SPSR;
            else if (sel < 95)
                it.cmd = brfs_pkg::CMD_SPSR2CPSR;
            else
                it.cmd = 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            cmd_fifo.push_back(it);
        end
        total = cmd_fifo.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (beats_in < total)
            @(posedge clk);
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d commands sent, %0d responses checked", beats_in, beats_out);
        $display("%0d bank switches, %0d rejected mode writes", mode_switches, bad_modes);
        if (errors == 0 && expected_rsp.size() == 0)
            $display("banked_register_file_with_status_test: clean");
        else
            $display("banked_register_file_with_status_test: errors");
        $finish;
    end

endmodule

/* sim.f */
sv/brfs_pkg.sv
sv/brfs_core.sv
sv/banked_register_file_with_status.sv
dv/banked_register_file_with_status_test.sv
